[rtl/core/json_string_unescape_core_assert.svh]
// Assertion macros for the unescape core.
// Each use is clocked on clk and disabled while rst_n is low.
`ifndef JSON_STRING_UNESCAPE_CORE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Condition must hold at every edge.
`define JSU_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When trig holds, cond must hold at the next edge.
`define JSU_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`else

`define JSU_ASSERT(lbl, cond, msg)
`define JSU_ASSERT_NEXT(lbl, trig, cond, msg)

`endif

`endif

[rtl/core/jsu_pkg.sv]
package jsu_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_STR  = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NO_QUOTE  = 3'd1,
        ERR_BAD_ESC   = 3'd2,
        ERR_BAD_HEX   = 3'd3,
        ERR_NON_ASCII = 3'd4,
        ERR_UNTERM    = 3'd5
    } err_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CP_MAX    = 8'h7F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       input_end;
    } raw_beat_t;

    typedef struct packed {
        logic [7:0] out_char;
        kind_t      result_kind;
        err_t       error_code;
    } dec_beat_t;

    // {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

[rtl/core/json_string_unescape_core.sv]
// JSON string unescape core: one raw byte in, at most one decoded beat out.
// A raw beat is captured in the input register, then decoded into the output register,
// visible on dec_valid, once that register is free or drained; while dec_stall holds a
// full output register, the beat waits in the input register. The decode step is a
// single state update. Throughput: one raw beat per cycle while dec_stall is low.
// Reset (rst_n low, asynchronous): both stages empty, decoder idle awaiting
// an opening quote, hex count and code point cleared.
module json_string_unescape_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                raw_valid,
    output logic                raw_stall,
    input  jsu_pkg::raw_beat_t  raw,
    output logic                dec_valid,
    input  logic                dec_stall,
    output jsu_pkg::dec_beat_t  dec
);
    import jsu_pkg::*;

    // Input register stage.
    logic       s1_valid_reg, s1_valid_next;
    raw_beat_t  s1_data_reg;

    // Decoder state.
    mode_t       mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] acc_reg, acc_next;

    // Output register stage.
    logic       out_valid_reg, out_valid_next;
    dec_beat_t  out_data_reg;

    logic       advance;
    logic       has_res;
    dec_beat_t  res;
    logic [4:0] hv;
    logic [15:0] acc_shift;

    // Assertion terms.
    logic       chk_kind_code;
    logic       chk_hex_clear;
    logic       chk_final;

    // Decode proceeds when the output register is free or being drained this cycle.
    assign advance   = s1_valid_reg && (!out_valid_reg || !dec_stall);
    assign raw_stall = s1_valid_reg && !advance;

    assign dec_valid = out_valid_reg;
    assign dec       = out_data_reg;

    assign hv        = hex_value(s1_data_reg.data_byte);
    assign acc_shift = {acc_reg[11:0], hv[3:0]};

    // Decode step: one byte against the current mode.
    always_comb
    begin
        has_res   = 1'b0;
        res       = '{out_char: 8'd0, result_kind: KIND_CHAR, error_code: ERR_NONE};
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;

        if (s1_data_reg.input_end) begin
            has_res          = 1'b1;
            res.result_kind  = KIND_ERR;
            res.error_code   = (mode_reg == MODE_IDLE) ? ERR_NO_QUOTE : ERR_UNTERM;
            mode_next        = MODE_IDLE;
            cnt_next         = 2'd0;
            acc_next         = 16'd0;
        end else begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    priority if (s1_data_reg.data_byte == CH_SPACE ||
                                 s1_data_reg.data_byte == CH_TAB ||
                                 s1_data_reg.data_byte == CH_LF ||
                                 s1_data_reg.data_byte == CH_CR) begin
                        // whitespace before the string: dropped
                    end else if (s1_data_reg.data_byte == CH_QUOTE) begin
                        mode_next = MODE_STR;
                    end else begin
                        has_res         = 1'b1;
                        res.result_kind = KIND_ERR;
                        res.error_code  = ERR_NO_QUOTE;
                    end
                end
                MODE_STR:
                begin
                    priority if (s1_data_reg.data_byte == CH_QUOTE) begin
                        has_res         = 1'b1;
                        res.result_kind = KIND_DONE;
                        mode_next       = MODE_IDLE;
                        cnt_next        = 2'd0;
                        acc_next        = 16'd0;
                    end else if (s1_data_reg.data_byte == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        has_res      = 1'b1;
                        res.out_char = s1_data_reg.data_byte;
                    end
                end
                MODE_ESC:
                begin
                    has_res   = 1'b1;
                    mode_next = MODE_STR;
                    unique case (s1_data_reg.data_byte)
                        CH_QUOTE:  res.out_char = CH_QUOTE;
                        CH_BSLASH: res.out_char = CH_BSLASH;
                        CH_SLASH:  res.out_char = CH_SLASH;
                        8'h62:     res.out_char = CH_BS;    // b
                        8'h66:     res.out_char = CH_FF;    // f
                        8'h6E:     res.out_char = CH_LF;    // n
                        8'h72:     res.out_char = CH_CR;    // r
                        8'h74:     res.out_char = CH_TAB;   // t
                        CH_U:
                        begin
                            has_res   = 1'b0;
                            mode_next = MODE_HEX;
                            cnt_next  = 2'd0;
                            acc_next  = 16'd0;
                        end
                        default:
                        begin
                            res.result_kind = KIND_ERR;
                            res.error_code  = ERR_BAD_ESC;
                            mode_next       = MODE_IDLE;
                            cnt_next        = 2'd0;
                            acc_next        = 16'd0;
                        end
                    endcase
                end
                MODE_HEX:
                begin
                    priority if (!hv[4]) begin
                        has_res         = 1'b1;
                        res.result_kind = KIND_ERR;
                        res.error_code  = ERR_BAD_HEX;
                        mode_next       = MODE_IDLE;
                        cnt_next        = 2'd0;
                        acc_next        = 16'd0;
                    end else if (cnt_reg != 2'd3) begin
                        cnt_next = cnt_reg + 2'd1;
                        acc_next = acc_shift;
                    end else begin
                        // fourth digit: range check the finished code point
                        has_res  = 1'b1;
                        cnt_next = 2'd0;
                        acc_next = 16'd0;
                        if (acc_shift > {8'd0, CP_MAX}) begin
                            res.result_kind = KIND_ERR;
                            res.error_code  = ERR_NON_ASCII;
                            mode_next       = MODE_IDLE;
                        end else begin
                            res.out_char = acc_shift[7:0];
                            mode_next    = MODE_STR;
                        end
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    // Stage valid flags.
    always_comb
    begin
        s1_valid_next  = raw_stall ? s1_valid_reg : raw_valid;
        out_valid_next = advance ? has_res : (out_valid_reg && dec_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_IDLE;
            cnt_reg       <= 2'd0;
            acc_reg       <= 16'd0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                mode_reg <= mode_next;
                cnt_reg  <= cnt_next;
                acc_reg  <= acc_next;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        if (raw_valid && !raw_stall) begin
            s1_data_reg <= raw;
        end
        if (advance && has_res) begin
            out_data_reg <= res;
        end
    end

    assign chk_kind_code = (out_data_reg.result_kind == KIND_ERR) ==
                           (out_data_reg.error_code != ERR_NONE);
    assign chk_hex_clear = (mode_reg == MODE_HEX) || (cnt_reg == 2'd0 && acc_reg == 16'd0);
    assign chk_final     = advance && has_res && (res.result_kind != KIND_CHAR);

`include "json_string_unescape_core_assert.svh"

    `JSU_ASSERT(a_err_has_code, !out_valid_reg || chk_kind_code, "error kind and code disagree")
    `JSU_ASSERT(a_hex_clear, chk_hex_clear, "hex state left over outside hex mode")
    `JSU_ASSERT_NEXT(a_end_idle, chk_final, mode_reg == MODE_IDLE, "not idle after done or error")
    `JSU_ASSERT_NEXT(a_s1_hold, raw_stall, s1_valid_reg && $stable(s1_data_reg), "stalled beat lost")

endmodule
